FILE: hdl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 3;
  localparam int INDEX_W = 4;

  // Command codes of the request channel.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  route_dest;
    logic [ADDR_W-1:0]  route_mask;
    logic [PORT_W-1:0]  route_port;
    logic               route_enable;
    logic [ADDR_W-1:0]  lookup_addr;
  } lpm_req_t;

  typedef struct packed {
    logic               found;
    logic [PORT_W-1:0]  out_port;
    logic [INDEX_W-1:0] match_index;
    logic [ADDR_W-1:0]  match_mask;
  } lpm_rsp_t;

  // Route entry as loaded into one cell.
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
    logic              enable;
  } lpm_entry_t;

  // Lookup probe handed from cell to cell, carrying the best match so far.
  typedef struct packed {
    logic               live;
    logic [ADDR_W-1:0]  addr;
    logic               hit;
    logic [PORT_W-1:0]  port;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  mask;
  } lpm_probe_t;

endpackage

`default_nettype wire

FILE: hdl/ipv4_longest_prefix_match.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  lpm_req_t  (write entry or look up address)
// rsp      out        rsp_valid / rsp_ready  lpm_rsp_t  (one per lookup, none per write)
//
// A write takes effect at its transfer. A lookup walks the row of ROUTES
// cells, one cell per cycle, and then lands in the response register; no
// request, write or lookup, is taken while it is in the cell row, so the
// next request waits until it has left the row.
// Reset clears every valid bit at once, so no clearing pass follows it. A
// stalled response holds its register; writes are still taken meanwhile, but
// a new lookup waits until the response register is free or being drained.
module ipv4_longest_prefix_match
  import lpm_pkg::*;
#(
  parameter int ROUTES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire lpm_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output lpm_rsp_t      rsp
);

  // Set while a lookup travels through the cells.
  logic busy;

  logic req_xfer;
  logic rsp_xfer;
  logic is_lookup;
  logic rsp_free;

  lpm_probe_t          probe [ROUTES+1];
  logic [ROUTES-1:0]   live_vec;
  lpm_entry_t          wr_entry;
  lpm_probe_t          tail;

  assign is_lookup = (req.command == CMD_LOOKUP);
  // The response register is free for a new lookup once it is empty or its
  // result transfers this cycle.
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = !busy && (!is_lookup || rsp_free);
  assign req_xfer  = req_valid && req_ready;
  assign rsp_xfer  = rsp_valid && rsp_ready;

  assign wr_entry.dest   = req.route_dest;
  assign wr_entry.mask   = req.route_mask;
  assign wr_entry.port   = req.route_port;
  assign wr_entry.enable = req.route_enable;

  // The probe enters the first cell with no match recorded.
  always_comb begin
    probe[0]       = '0;
    probe[0].live  = req_xfer && is_lookup;
    probe[0].addr  = req.lookup_addr;
  end

  for (genvar i = 0; i < ROUTES; i++) begin : g_cell
    logic wr_sel;

    // Slots at or above ROUTES match no cell, so such writes are dropped.
    assign wr_sel = req_xfer && !is_lookup && (32'(req.entry_index) == i);

    lpm_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_sel),
      .wr_entry (wr_entry),
      .probe_in (probe[i]),
      .probe_out(probe[i+1])
    );

    assign live_vec[i] = probe[i+1].live;
  end

  assign tail = probe[ROUTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_xfer && is_lookup) begin
      busy <= 1'b1;
    end else if (tail.live) begin
      busy <= 1'b0;
    end
  end

  // Response register. A miss reports all fields as zero, which the probe
  // already carries since nothing was recorded.
  always_ff @(posedge clk) begin
    if (tail.live) begin
      rsp.found       <= tail.hit;
      rsp.out_port    <= tail.port;
      rsp.match_index <= tail.index;
      rsp.match_mask  <= tail.mask;
    end
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (tail.live) begin
      rsp_valid <= 1'b1;
    end else if (rsp_xfer) begin
      rsp_valid <= 1'b0;
    end
  end

  // At most one lookup is ever in the cell row.
  a_single_probe : assert property (@(posedge clk) disable iff (rst)
    $onehot0(live_vec))
    else $error("more than one lookup in the cell row");

  // A probe in the row always has busy standing behind it.
  a_busy_cover : assert property (@(posedge clk) disable iff (rst)
    (|live_vec) |-> busy)
    else $error("lookup in flight while not busy");

  // A new response is never loaded over one still waiting.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> !$past(tail.live))
    else $error("response register overwritten");

  // A miss reports zero in every field.
  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |->
      (rsp.out_port == '0) && (rsp.match_index == '0) && (rsp.match_mask == '0))
    else $error("miss with nonzero fields");

endmodule

`default_nettype wire

FILE: hdl/lpm_cell.sv
`default_nettype none

module lpm_cell
  import lpm_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire lpm_entry_t wr_entry,
  input  wire lpm_probe_t probe_in,
  output lpm_probe_t      probe_out
);

  logic [ADDR_W-1:0] dest;
  logic [ADDR_W-1:0] mask;
  logic [PORT_W-1:0] port;
  logic              valid;

  logic       hit_here;
  logic       take;
  lpm_probe_t probe_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dest <= wr_entry.dest;
      mask <= wr_entry.mask;
      port <= wr_entry.port;
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= wr_entry.enable;
    end
  end

  // A strictly larger mask is needed to displace an earlier match, so the
  // lower slot wins on equal prefixes.
  always_comb begin
    hit_here   = valid && (((dest ^ probe_in.addr) & mask) == '0);
    take       = hit_here && (!probe_in.hit || (mask > probe_in.mask));
    probe_next = probe_in;
    if (take) begin
      probe_next.hit   = 1'b1;
      probe_next.port  = port;
      probe_next.index = INDEX_W'(CELL_INDEX);
      probe_next.mask  = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

`default_nettype wire

FILE: verif/lpm_route_checker.sv
`default_nettype none

// Watches both channels of the route table, keeps its own copy of the table
// and works out the answer to every lookup when its request transfer is seen.
module lpm_route_checker
  import lpm_pkg::*;
#(
  parameter int ROUTES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_ready,
  input  wire lpm_req_t req,
  input  wire logic     rsp_valid,
  input  wire logic     rsp_ready,
  input  wire lpm_rsp_t rsp,
  output int            mismatches,
  output int            awaited
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [ADDR_W-1:0] dest_tbl [ROUTES];
  logic [ADDR_W-1:0] mask_tbl [ROUTES];
  logic [PORT_W-1:0] port_tbl [ROUTES];
  bit                live_tbl [ROUTES];
  lpm_rsp_t          answers_q [$];
  lpm_rsp_t          want;

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] route check: %s", $time, msg);
  endtask

  // Longest numeric mask among the valid matching entries; the lower slot
  // keeps the win on a tie because only a strictly larger mask replaces it.
  function automatic lpm_rsp_t best_route(input logic [ADDR_W-1:0] addr);
    lpm_rsp_t best;
    best = '0;
    for (int i = 0; i < ROUTES; i++) begin
      if (live_tbl[i] && ((dest_tbl[i] ^ addr) & mask_tbl[i]) == '0 &&
          (!best.found || mask_tbl[i] > best.match_mask)) begin
        best.found       = 1'b1;
        best.out_port    = port_tbl[i];
        best.match_index = INDEX_W'(i);
        best.match_mask  = mask_tbl[i];
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROUTES; i++) live_tbl[i] = 1'b0;
      answers_q.delete();
    end else begin
      // The response is checked first: a lookup taken in this same cycle
      // cannot be the one being answered.
      if (rsp_valid && rsp_ready) begin
        if (answers_q.size() == 0) begin
          report_mismatch("response transfer with no lookup outstanding");
        end else begin
          want = answers_q.pop_front();
          if (rsp.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", rsp.found, want.found));
          if (rsp.out_port !== want.out_port)
            report_mismatch($sformatf("out_port %0d, expected %0d",
                                      rsp.out_port, want.out_port));
          if (rsp.match_index !== want.match_index)
            report_mismatch($sformatf("match_index %0d, expected %0d",
                                      rsp.match_index, want.match_index));
          if (rsp.match_mask !== want.match_mask)
            report_mismatch($sformatf("match_mask %h, expected %h",
                                      rsp.match_mask, want.match_mask));
        end
      end
      if (req_valid && req_ready) begin
        if (req.command == CMD_WRITE) begin
          if (int'(req.entry_index) < ROUTES) begin
            dest_tbl[req.entry_index] = req.route_dest;
            mask_tbl[req.entry_index] = req.route_mask;
            port_tbl[req.entry_index] = req.route_port;
            live_tbl[req.entry_index] = req.route_enable;
          end
        end else begin
          answers_q.push_back(best_route(req.lookup_addr));
        end
      end
    end
    awaited <= answers_q.size();
  end

endmodule

`default_nettype wire

FILE: verif/ipv4_longest_prefix_match_tb.sv
`default_nettype none

// Stimulus and verdict for the route table. The checker beside the block does
// all of the prediction and comparison; this module only offers requests,
// paces the response side and decides the outcome of the run.
module ipv4_longest_prefix_match_tb;

  import lpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUTES       = 16;
  localparam int RANDOM_ITEMS = 1330;
  // Longest correct stretch without a transfer is the long response hold
  // plus one lookup walk, so this leaves a wide margin.
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 250;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lpm_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lpm_rsp_t rsp;

  int mismatches;
  int awaited;
  int quiet_cycles = 0;
  int responses    = 0;

  // Pacing state: each side runs in stretches that are either calm (no
  // waiting at all) or choppy (a fresh random wait drawn for each item).
  int send_run  = 0;
  bit send_calm = 1'b0;
  int take_run  = 0;
  bit take_calm = 1'b0;

  // Stimulus-side record of what has been written, used only to aim
  // lookups at addresses that actually hit something.
  logic [ADDR_W-1:0] aim_dest [ROUTES];
  logic [ADDR_W-1:0] aim_mask [ROUTES];
  bit                aim_used [ROUTES];
  logic [ADDR_W-1:0] prefix_pool [4];

  always #6 clk = ~clk;

  ipv4_longest_prefix_match #(.ROUTES(ROUTES)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  lpm_route_checker #(.ROUTES(ROUTES)) route_chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  function automatic int draw_pause(inout int run, inout bit calm);
    if (run == 0) begin
      run  = $urandom_range(5, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
    return (len == 0) ? '0 : ~(ADDR_W'(0)) << (ADDR_W - len);
  endfunction

  // Offers one request and returns once its transfer has happened. With no
  // pause drawn, valid simply stays high and only the payload moves on.
  task automatic offer(input lpm_req_t item);
    int pause;
    pause = draw_pause(send_run, send_calm);
    if (pause > 0) begin
      req_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // The fields that a command does not use still carry random values, so
  // that every bit of the payload moves on both kinds of request.
  task automatic put_route(input logic [INDEX_W-1:0] slot, input logic [ADDR_W-1:0] dest,
                           input logic [ADDR_W-1:0] mask, input logic [PORT_W-1:0] port,
                           input logic enable);
    lpm_req_t item;
    item.command      = CMD_WRITE;
    item.entry_index  = slot;
    item.route_dest   = dest;
    item.route_mask   = mask;
    item.route_port   = port;
    item.route_enable = enable;
    item.lookup_addr  = $urandom;
    aim_dest[slot] = dest;
    aim_mask[slot] = mask;
    aim_used[slot] = enable;
    offer(item);
  endtask

  task automatic ask(input logic [ADDR_W-1:0] addr);
    lpm_req_t item;
    item.command      = CMD_LOOKUP;
    item.entry_index  = INDEX_W'($urandom);
    item.route_dest   = $urandom;
    item.route_mask   = $urandom;
    item.route_port   = PORT_W'($urandom);
    item.route_enable = 1'($urandom);
    item.lookup_addr  = addr;
    offer(item);
  endtask

  // Picks an address: half the time inside a valid entry (random host bits), else
  // near one of the shared prefixes, else anywhere at all.
  function automatic logic [ADDR_W-1:0] pick_address();
    int               slot;
    logic [ADDR_W-1:0] noise;
    noise = $urandom;
    slot  = $urandom_range(0, ROUTES - 1);
    case ($urandom_range(0, 3))
      0, 1: begin
        for (int i = 0; i < ROUTES && !aim_used[slot]; i++) slot = (slot + 1) % ROUTES;
        if (aim_used[slot]) return (aim_dest[slot] & aim_mask[slot]) | (noise & ~aim_mask[slot]);
        return noise;
      end
      2: return prefix_pool[$urandom_range(0, 3)] ^ (noise >> $urandom_range(4, 31));
      default: return noise;
    endcase
  endfunction

  task automatic random_route();
    int               len;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] dest;
    len  = $urandom_range(0, 32);
    mask = ($urandom_range(0, 7) == 0) ? $urandom : prefix_mask(len);
    dest = $urandom;
    if ($urandom_range(0, 4) != 0)
      dest = (prefix_pool[$urandom_range(0, 3)] & mask) | (dest & ~mask);
    put_route(INDEX_W'($urandom), dest, mask, PORT_W'($urandom),
              $urandom_range(0, 6) != 0);
  endtask

  // Response side. Around the eightieth and the six hundredth response it
  // refuses responses for a long stretch, so the next lookup waits behind the
  // response register while writes offered ahead of it still go through.
  initial begin
    int pause;
    @(negedge rst);
    @(posedge clk);
    forever begin
      pause = draw_pause(take_run, take_calm);
      if (responses == 80 || responses == 600) pause = HOLD_CYCLES;
      if (pause > 0) begin
        rsp_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      responses++;
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ipv4_longest_prefix_match regression: fail");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ROUTES; i++) aim_used[i] = 1'b0;
    for (int i = 0; i < 4; i++) prefix_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. An empty table must miss everything.
    ask(32'h0000_0000);
    // A default route matches any address, here the all-ones one.
    put_route(4'd0, 32'h0000_0000, 32'h0000_0000, 3'd5, 1'b1);
    ask(32'hFFFF_FFFF);
    // Host route in the top slot with every field at its upper extreme.
    put_route(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1);
    ask(32'hFFFF_FFFF);
    ask(32'hFFFF_FFFE);
    // Two entries with equal masks: the lower slot must win.
    put_route(4'd7, 32'h0A00_0000, 32'hFF00_0000, 3'd6, 1'b1);
    put_route(4'd3, 32'h0A00_0000, 32'hFF00_0000, 3'd2, 1'b1);
    ask(32'h0A12_3456);
    // A longer prefix nested inside the /8 takes over.
    put_route(4'd8, 32'h0A12_0000, 32'hFFFF_0000, 3'd0, 1'b1);
    ask(32'h0A12_FFFF);
    ask(32'h0A13_0000);
    // Clearing the entry stores it but takes it out of the running.
    put_route(4'd8, 32'h0A12_0000, 32'hFFFF_0000, 3'd1, 1'b0);
    ask(32'h0A12_FFFF);
    // A non-contiguous mask still ranks by its numeric value.
    put_route(4'd9, 32'h0A00_1200, 32'hFF00_FF00, 3'd4, 1'b1);
    ask(32'h0A00_1234);
    ask(32'h0A00_1334);
    // With the default route withdrawn an unrelated address misses again.
    put_route(4'd0, 32'h0000_0000, 32'h0000_0000, 3'd3, 1'b0);
    ask(32'h1234_5678);
    ask(32'h0000_0000);

    // Random part: about a third writes, the rest lookups.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 2) == 0) random_route();
      else ask(pick_address());
    end
    req_valid <= 1'b0;

    // The count of outstanding lookups is a register, so it settles in the
    // cycle after the last request transfer.
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (ROUTES + 8) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("ipv4_longest_prefix_match regression: pass");
    end else begin
      $display("ipv4_longest_prefix_match regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
